@@ rtl/pbe_pkg.sv @@
package pbe_pkg;

  localparam int unsigned PinBytesDef = 128;
  localparam int unsigned BufBytesDef = 64;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // width used for length and size compares
  localparam int unsigned VW = 10;

  localparam int unsigned GlpBlockBytes = 8;
  localparam int unsigned GlpMaxDigits  = 12;

  localparam logic [7:0] GlpHdrNibble = 8'h20;
  localparam logic [7:0] FillByte     = 8'hFF;
  localparam logic [7:0] AsciiZero    = 8'h30;
  localparam logic [7:0] AsciiNine    = 8'h39;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE    = 3'd0,
    REG_MAX_LEN = 3'd1,
    REG_PAD     = 3'd2,
    REG_PAD_EN  = 3'd3,
    REG_BUF_LEN = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_ASCII = 2'd0,
    MODE_BCD   = 2'd1,
    MODE_GLP   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_SMALL   = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] pin_byte;
    logic       last_byte;
    logic       empty_pin;
  } pin_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
    logic [1:0] status;
    logic [6:0] byte_count;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic decide;
    logic rd_second;
    logic form_load;
    logic status_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pin_end;
    logic done_now;
    logic out_free;
    logic last_k;
  } dp_stat_t;

endpackage

@@ rtl/pbe_stream_if.sv @@
interface pbe_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/pbe_ctrl.sv @@
module pbe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pbe_pkg::dp_stat_t stat_i,
  output pbe_pkg::cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_LOAD   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_STATUS = 6'b000100,
    S_RD_A   = 6'b001000,
    S_RD_B   = 6'b010000,
    S_FORM   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_LOAD: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.pin_end) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = stat_i.done_now ? S_STATUS : S_RD_A;
      end
      S_STATUS: begin
        if (stat_i.out_free) begin
          cmd_o.status_load = 1'b1;
          state_d = S_LOAD;
        end
      end
      S_RD_A: begin
        // if the output register is free now, nothing loads it before S_FORM does
        if (stat_i.out_free) begin
          state_d = S_RD_B;
        end
      end
      S_RD_B: begin
        cmd_o.rd_second = 1'b1;
        state_d = S_FORM;
      end
      S_FORM: begin
        cmd_o.form_load = 1'b1;
        state_d = stat_i.last_k ? S_LOAD : S_RD_A;
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  a_decide_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE) |-> $past(stat_i.pin_end && state_q == S_LOAD))
    else $error("decide entered without a pin-ending transaction");

endmodule

@@ rtl/pbe_datapath.sv @@
module pbe_datapath #(
  parameter int unsigned MAX_PIN_BYTES    = pbe_pkg::PinBytesDef,
  parameter int unsigned MAX_BUFFER_BYTES = pbe_pkg::BufBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pbe_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pbe_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          pin_valid_i,
  input  pbe_pkg::pin_t                 pin_i,
  input  pbe_pkg::cmd_t                 cmd_i,
  output pbe_pkg::dp_stat_t             stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pbe_pkg::res_t                 res_o
);

  localparam int unsigned AW = $clog2(MAX_PIN_BYTES);
  localparam int unsigned CW = $clog2(MAX_PIN_BYTES + 1);
  localparam int unsigned VW = pbe_pkg::VW;

  // configuration registers
  logic [1:0] mode_q;
  logic [7:0] max_len_q;
  logic [7:0] pad_q;
  logic       pad_en_q;
  logic [6:0] buf_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= pbe_pkg::MODE_ASCII;
      max_len_q <= 8'd0;
      pad_q     <= pbe_pkg::FillByte;
      pad_en_q  <= 1'b0;
      buf_len_q <= 7'(MAX_BUFFER_BYTES);
    end else if (cfg_we_i) begin
      case (pbe_pkg::cfg_idx_e'(cfg_idx_i))
        pbe_pkg::REG_MODE:    mode_q    <= cfg_wdata_i[1:0];
        pbe_pkg::REG_MAX_LEN: max_len_q <= cfg_wdata_i;
        pbe_pkg::REG_PAD:     pad_q     <= cfg_wdata_i;
        pbe_pkg::REG_PAD_EN:  pad_en_q  <= cfg_wdata_i[0];
        pbe_pkg::REG_BUF_LEN: buf_len_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  logic glp, bcd, pack;
  assign glp  = (mode_q == pbe_pkg::MODE_GLP);
  assign bcd  = (mode_q == pbe_pkg::MODE_BCD);
  assign pack = glp | bcd;

  // pin store and load-side tracking
  logic [7:0]    store [MAX_PIN_BYTES];
  logic [7:0]    mem_q;
  logic [AW-1:0] raddr;

  logic [CW-1:0] cnt_q;
  logic [CW-1:0] trim_q;
  logic          ovf_q;
  logic          seen_ff_q;
  logic          bad_q;

  logic       load_en, wr_en, b_ff, b_digit;
  logic [7:0] b;

  assign b       = pin_i.pin_byte;
  assign load_en = pin_valid_i & cmd_i.in_ready & ~pin_i.empty_pin;
  assign wr_en   = load_en & (cnt_q < CW'(MAX_PIN_BYTES));
  assign b_ff    = (b == pbe_pkg::FillByte);
  assign b_digit = (b >= pbe_pkg::AsciiZero) && (b <= pbe_pkg::AsciiNine);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store[cnt_q[AW-1:0]] <= b;
    end
    mem_q <= store[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      trim_q    <= '0;
      ovf_q     <= 1'b0;
      seen_ff_q <= 1'b0;
      bad_q     <= 1'b0;
    end else if (cmd_i.decide) begin
      cnt_q     <= '0;
      trim_q    <= '0;
      ovf_q     <= 1'b0;
      seen_ff_q <= 1'b0;
      bad_q     <= 1'b0;
    end else if (wr_en) begin
      cnt_q <= cnt_q + CW'(1);
      if (b_ff) begin
        seen_ff_q <= 1'b1;
      end else begin
        // trailing 0xff trim point, and any non-digit inside the trimmed pin
        trim_q <= cnt_q + CW'(1);
        if (seen_ff_q || !b_digit) begin
          bad_q <= 1'b1;
        end
      end
    end else if (load_en) begin
      ovf_q <= 1'b1;
    end
  end

  // length and buffer checks at the end of a pin
  logic [6:0]    blen7;
  logic [VW-1:0] cnt_w, trim_w, mx_w, bl_w, len_w, dlen_w, need_w, padl_w, n_w;
  pbe_pkg::status_e dec_st;

  always_comb begin
    blen7  = (buf_len_q > 7'(MAX_BUFFER_BYTES)) ? 7'(MAX_BUFFER_BYTES) : buf_len_q;
    cnt_w  = VW'(cnt_q);
    trim_w = VW'(trim_q);
    mx_w   = VW'(max_len_q);
    bl_w   = VW'(blen7);
    len_w  = glp ? trim_w : cnt_w;
    dlen_w = pack ? ((len_w + VW'(1)) >> 1) : len_w;
    need_w = dlen_w + VW'(glp);
    if (glp) begin
      padl_w = VW'(pbe_pkg::GlpBlockBytes);
    end else if (pad_en_q) begin
      padl_w = bcd ? (mx_w >> 1) : mx_w;
    end else begin
      padl_w = '0;
    end
    n_w = (need_w > padl_w) ? need_w : padl_w;

    if (ovf_q) begin
      dec_st = pbe_pkg::ST_SMALL;
    end else if ((mx_w != '0) && (cnt_w > mx_w)) begin
      dec_st = pbe_pkg::ST_INVALID;
    end else if (glp && ((trim_w > VW'(pbe_pkg::GlpMaxDigits)) || bad_q)) begin
      dec_st = pbe_pkg::ST_INVALID;
    end else if (glp && (bl_w < VW'(pbe_pkg::GlpBlockBytes))) begin
      dec_st = pbe_pkg::ST_SMALL;
    end else if (need_w > bl_w) begin
      dec_st = pbe_pkg::ST_SMALL;
    end else if (padl_w > bl_w) begin
      dec_st = pbe_pkg::ST_SMALL;
    end else begin
      dec_st = pbe_pkg::ST_OK;
    end
  end

  pbe_pkg::status_e st_q;
  logic [6:0] n_q;
  logic [6:0] dlen_q;
  logic       odd_q;
  logic [3:0] hdr_q;
  logic [6:0] k_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      st_q   <= dec_st;
      n_q    <= 7'(n_w);
      dlen_q <= 7'(dlen_w);
      odd_q  <= len_w[0];
      hdr_q  <= trim_q[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.decide) begin
      k_q <= '0;
    end else if (cmd_i.form_load) begin
      k_q <= k_q + 7'd1;
    end
  end

  // emit side: the first read gives the high nibble (or the whole ASCII byte), the second the low nibble
  logic [6:0] base7;
  logic [7:0] pidx8;
  logic [7:0] raddr8;
  logic [7:0] a_q;
  logic       is_data, last_data;
  logic [7:0] pair, form_byte;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_second) begin
      a_q <= mem_q;
    end
  end

  always_comb begin
    base7     = glp ? (k_q - 7'd1) : k_q;
    pidx8     = pack ? {base7, 1'b0} : {1'b0, base7};
    raddr8    = cmd_i.rd_second ? (pidx8 + 8'd1) : pidx8;
    raddr     = raddr8[AW-1:0];
    is_data   = (base7 < dlen_q) && !(glp && (k_q == 7'd0));
    last_data = (base7 == (dlen_q - 7'd1));
    pair      = {a_q[3:0], (odd_q && last_data) ? pad_q[3:0] : mem_q[3:0]};
    if (glp && (k_q == 7'd0)) begin
      form_byte = pbe_pkg::GlpHdrNibble | {4'h0, hdr_q};
    end else if (is_data) begin
      form_byte = pack ? pair : a_q;
    end else begin
      form_byte = glp ? pbe_pkg::FillByte : pad_q;
    end
  end

  // output register
  logic          out_valid_q;
  pbe_pkg::res_t out_q;
  logic          out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.form_load || cmd_i.status_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.status_load) begin
      out_q.out_byte   <= 8'h00;
      out_q.last_out   <= 1'b1;
      out_q.status     <= st_q;
      out_q.byte_count <= 7'd0;
    end else if (cmd_i.form_load) begin
      out_q.out_byte   <= form_byte;
      out_q.last_out   <= stat_o.last_k;
      out_q.status     <= pbe_pkg::ST_OK;
      out_q.byte_count <= n_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  assign stat_o.pin_end  = pin_valid_i & (pin_i.last_byte | pin_i.empty_pin);
  assign stat_o.done_now = (dec_st != pbe_pkg::ST_OK) || (n_w == '0);
  assign stat_o.out_free = out_free;
  assign stat_o.last_k   = (k_q == (n_q - 7'd1));

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.form_load || cmd_i.status_load) |-> out_free)
    else $error("result register overwritten before its transaction");

  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.form_load |-> (k_q < n_q))
    else $error("emit index past encoded length");

  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.status_load) |-> (out_q.last_out && (out_q.byte_count == 7'd0)))
    else $error("status result carries data");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (cnt_q == CW'(MAX_PIN_BYTES)))
    else $error("overflow flagged before store full");

endmodule

@@ rtl/pin_block_encoder.sv @@
// channel  | dir | payload                                 | accepted when
// pin_i    | in  | pin_byte, last_byte, empty_pin          | valid & ready
// enc_o    | out | out_byte, last_out, status, byte_count  | valid & ready
// cfg      | in  | cfg_idx_i, cfg_wdata_i                  | cfg_we_i
//
// pin bytes load one per cycle; ready drops from the pin-ending transaction
// until the last result of that pin sits in the output register
// lengths are checked in S_DECIDE, then each encoded byte takes two store
// reads through the single registered read port, then the result register
// an error or empty result goes through S_DECIDE and S_STATUS after the pin ends
// reset clears control and configuration; the pin store is not cleared
// a stall on enc_o holds the emit sequence; pin_i is taken again while
// the final result waits
module pin_block_encoder #(
  parameter int unsigned MAX_PIN_BYTES    = pbe_pkg::PinBytesDef,
  parameter int unsigned MAX_BUFFER_BYTES = pbe_pkg::BufBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pbe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pbe_pkg::CfgDataW-1:0] cfg_wdata_i,
  pbe_stream_if.sink                   pin_i,
  pbe_stream_if.source                 enc_o
);

  pbe_pkg::cmd_t     cmd;
  pbe_pkg::dp_stat_t stat;
  pbe_pkg::pin_t     pin_payload;
  pbe_pkg::res_t     res;
  logic              out_valid;

  assign pin_payload = pin_i.payload;
  assign pin_i.ready = cmd.in_ready;

  pbe_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  pbe_datapath #(
    .MAX_PIN_BYTES    (MAX_PIN_BYTES),
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pin_valid_i (pin_i.valid),
    .pin_i       (pin_payload),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid),
    .out_ready_i (enc_o.ready),
    .res_o       (res)
  );

  assign enc_o.valid   = out_valid;
  assign enc_o.payload = res;

endmodule
